FILE: rtl/device_table_aging_macros.svh
// Assertion helpers used by device_table_aging.sv.
`ifndef DEVICE_TABLE_AGING_MACROS_SVH
`define DEVICE_TABLE_AGING_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("device table check failed");

// Next-cycle implication, checked outside reset
`define DTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("device table check failed");

`endif

FILE: rtl/dta_pkg.sv
package dta_pkg;

    // Default table size and expiry age after reset
    localparam int          TABLE_DEPTH_DEF = 64;
    localparam logic [31:0] TIMEOUT_RESET   = 32'd120000;
    // Most entries one dump emits
    localparam logic [6:0]  MAX_DUMP        = 7'd64;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_EXPIRE  = 2'd1,
        CMD_DUMP    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_EXPIRED    = 3'd3,
        ST_DUMP_ENTRY = 3'd4,
        ST_DUMP_EMPTY = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OBS_SCAN,
        S_OBS_DONE,
        S_EXP_RD,
        S_EXP_CHK,
        S_EXP_MOVE,
        S_EXP_DONE,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_DUMP_EMPTY
    } state_t;

    // One table slot as held in memory
    typedef struct packed {
        logic [31:0]        seen;
        logic signed [7:0]  strength;
        logic [47:0]        key;
    } entry_t;

endpackage

FILE: rtl/dta_ram.sv
module dta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(DEPTH)-1:0]       wr_addr,
    input  logic [WIDTH-1:0]               wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(DEPTH)-1:0]       rd_addr,
    output logic [WIDTH-1:0]               rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/device_table_aging.sv
// Channel   | Dir | Handshake          | Content
// ----------+-----+--------------------+--------------------------------------------
// s_        | in  | s_tvalid/s_tready  | tuser: command; tdata: address, rssi, time
// m_        | out | m_tvalid/m_tready  | tdata: status .. last_seen; tlast: last
// cfg_      | in  | cfg_wen            | cfg_wdata: timeout in ms
//
// One item at a time; every step goes through the single read port of the
// table memory. Observe scans the valid entries for the key; expire reads each
// entry and refills a removed slot from the last one; dump reads each entry out.
// Reset (aresetn low, synchronous) empties the table at once: no clearing pass.
// A stalled m_ side holds the sequencer only when it has a result to hand over.
`include "device_table_aging_macros.svh"

module device_table_aging #(
    parameter int TABLE_DEPTH = dta_pkg::TABLE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // device_address[47:0], signal_strength[55:48],
                                    // now_ms[87:56], max_out[94:88], zero pad[95]
    input  logic [1:0]   s_tuser,   // command[1:0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // status[2:0], entry_index[8:3], entry_count[15:9],
                                    // entry_address[63:16], entry_strength[71:64],
                                    // entry_last_seen[103:72]
    output logic         m_tlast
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (CW > 7) ? CW : 7;
    localparam int EW = $bits(dta_pkg::entry_t);

    dta_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic               hit_reg, hit_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [NW-1:0]      dump_n_reg, dump_n_next;
    logic [31:0]        timeout_reg;
    logic [47:0]        addr_reg, addr_next;
    logic signed [7:0]  str_reg, str_next;
    logic [31:0]        now_reg, now_next;

    logic               m_tvalid_reg;
    dta_pkg::status_t   ostatus_reg, ostatus_next;
    logic [5:0]         oidx_reg, oidx_next;
    logic [6:0]         ocount_reg, ocount_next;
    dta_pkg::entry_t    oentry_reg, oentry_next;
    logic               olast_reg, olast_next;
    logic               out_load;

    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    dta_pkg::entry_t    ram_wr_data;
    logic [EW-1:0]      ram_rd_data;
    dta_pkg::entry_t    rd_entry;

    logic               s_fire, out_free, scan_hit, ptr_lt_count, expired, dump_last;
    logic               table_full;
    logic [31:0]        age;
    logic [CW-1:0]      cnt_dec, ptr_inc;
    logic [6:0]         dump_lim;
    logic [NW-1:0]      dump_n_new;
    dta_pkg::cmd_t      s_cmd;

    // Table memory: key, strength and last-seen time side by side
    dta_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_entry = dta_pkg::entry_t'(ram_rd_data);

    // Shared conditions
    assign s_cmd        = dta_pkg::cmd_t'(s_tuser);
    assign s_tready     = (state_reg == dta_pkg::S_IDLE);
    assign s_fire       = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign scan_hit     = pend_reg && (rd_entry.key == addr_reg);
    assign ptr_lt_count = (ptr_reg < count_reg);
    assign age          = now_reg - rd_entry.seen;
    assign expired      = (age > timeout_reg);
    assign cnt_dec      = count_reg - CW'(1);
    assign ptr_inc      = ptr_reg + CW'(1);
    assign table_full   = (count_reg == CW'(TABLE_DEPTH));
    assign dump_last    = (NW'(NW'(ptr_reg) + NW'(1)) == dump_n_reg);
    assign dump_lim     = (s_tdata[94:88] > dta_pkg::MAX_DUMP) ? dta_pkg::MAX_DUMP
                                                                : s_tdata[94:88];
    assign dump_n_new   = (NW'(count_reg) < NW'(dump_lim)) ? NW'(count_reg) : NW'(dump_lim);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dta_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (s_cmd)
                        dta_pkg::CMD_OBSERVE: state_next = dta_pkg::S_OBS_SCAN;
                        dta_pkg::CMD_EXPIRE:  state_next = dta_pkg::S_EXP_RD;
                        dta_pkg::CMD_DUMP: begin
                            state_next = (dump_n_new == '0) ? dta_pkg::S_DUMP_EMPTY
                                                            : dta_pkg::S_DUMP_RD;
                        end
                        default: state_next = dta_pkg::S_IDLE;
                    endcase
                end
            end
            dta_pkg::S_OBS_SCAN: begin
                if (scan_hit || (!ptr_lt_count && !pend_reg)) begin
                    state_next = dta_pkg::S_OBS_DONE;
                end
            end
            dta_pkg::S_EXP_RD: begin
                state_next = ptr_lt_count ? dta_pkg::S_EXP_CHK : dta_pkg::S_EXP_DONE;
            end
            dta_pkg::S_EXP_CHK: begin
                state_next = expired ? dta_pkg::S_EXP_MOVE : dta_pkg::S_EXP_RD;
            end
            dta_pkg::S_EXP_MOVE: state_next = dta_pkg::S_EXP_RD;
            dta_pkg::S_DUMP_RD:  state_next = dta_pkg::S_DUMP_EMIT;
            dta_pkg::S_DUMP_EMIT: begin
                if (out_free) begin
                    state_next = dump_last ? dta_pkg::S_IDLE : dta_pkg::S_DUMP_RD;
                end
            end
            dta_pkg::S_OBS_DONE, dta_pkg::S_EXP_DONE, dta_pkg::S_DUMP_EMPTY: begin
                if (out_free) begin
                    state_next = dta_pkg::S_IDLE;
                end
            end
            default: state_next = dta_pkg::S_IDLE;
        endcase
    end

    // Memory accesses, counters and result loading
    always_comb begin
        ptr_next     = ptr_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        hit_next     = hit_reg;
        count_next   = count_reg;
        dump_n_next  = dump_n_reg;
        addr_next    = addr_reg;
        str_next     = str_reg;
        now_next     = now_reg;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = ptr_reg[AW-1:0];
        ram_wr_en    = 1'b0;
        ram_wr_addr  = ptr_reg[AW-1:0];
        ram_wr_data  = rd_entry;
        out_load     = 1'b0;
        ostatus_next = ostatus_reg;
        oidx_next    = oidx_reg;
        ocount_next  = ocount_reg;
        oentry_next  = oentry_reg;
        olast_next   = olast_reg;
        case (state_reg)
            dta_pkg::S_IDLE: begin
                // Latch the item and rewind the walk
                if (s_fire) begin
                    addr_next   = s_tdata[47:0];
                    str_next    = s_tdata[55:48];
                    now_next    = s_tdata[87:56];
                    ptr_next    = '0;
                    hit_next    = 1'b0;
                    dump_n_next = dump_n_new;
                end
            end
            dta_pkg::S_OBS_SCAN: begin
                // Stream reads and compare each key in the cycle after its read
                if (scan_hit) begin
                    hit_next = 1'b1;
                end else if (ptr_lt_count) begin
                    ram_rd_en = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            dta_pkg::S_OBS_DONE: begin
                // Write back refreshed or new entry, or drop it when full, and report it
                if (out_free) begin
                    out_load           = 1'b1;
                    olast_next         = 1'b1;
                    ram_wr_data.key      = addr_reg;
                    ram_wr_data.strength = str_reg;
                    ram_wr_data.seen     = now_reg;
                    oentry_next        = ram_wr_data;
                    if (hit_reg) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = pidx_reg;
                        ostatus_next = dta_pkg::ST_UPDATED;
                        oidx_next    = 6'(pidx_reg);
                        ocount_next  = 7'(count_reg);
                    end else if (!table_full) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = count_reg[AW-1:0];
                        count_next   = count_reg + CW'(1);
                        ostatus_next = dta_pkg::ST_INSERTED;
                        oidx_next    = 6'(count_reg);
                        ocount_next  = 7'(count_next);
                    end else begin
                        ostatus_next = dta_pkg::ST_DROPPED;
                        oidx_next    = '0;
                        ocount_next  = 7'(count_reg);
                        oentry_next  = '0;
                    end
                end
            end
            dta_pkg::S_EXP_RD: begin
                if (ptr_lt_count) begin
                    ram_rd_en = 1'b1;
                end
            end
            dta_pkg::S_EXP_CHK: begin
                // Fetch the last entry to refill a stale slot, else advance
                if (expired) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = cnt_dec[AW-1:0];
                end else begin
                    ptr_next = ptr_inc;
                end
            end
            dta_pkg::S_EXP_MOVE: begin
                // Move last entry into the slot, shrink, recheck the slot
                ram_wr_en  = 1'b1;
                count_next = cnt_dec;
            end
            dta_pkg::S_DUMP_RD: begin
                ram_rd_en = 1'b1;
            end
            dta_pkg::S_DUMP_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    ostatus_next = dta_pkg::ST_DUMP_ENTRY;
                    oidx_next    = 6'(ptr_reg);
                    ocount_next  = 7'(count_reg);
                    oentry_next  = rd_entry;
                    olast_next   = dump_last;
                    ptr_next     = ptr_inc;
                end
            end
            dta_pkg::S_EXP_DONE, dta_pkg::S_DUMP_EMPTY: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    ostatus_next = (state_reg == dta_pkg::S_EXP_DONE) ? dta_pkg::ST_EXPIRED
                                                                      : dta_pkg::ST_DUMP_EMPTY;
                    oidx_next    = '0;
                    ocount_next  = 7'(count_reg);
                    oentry_next  = '0;
                    olast_next   = 1'b1;
                end
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dta_pkg::S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            timeout_reg  <= dta_pkg::TIMEOUT_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cfg_wen) begin
                timeout_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        pidx_reg   <= pidx_next;
        hit_reg    <= hit_next;
        dump_n_reg <= dump_n_next;
        addr_reg   <= addr_next;
        str_reg    <= str_next;
        now_reg    <= now_next;
        if (out_load) begin
            ostatus_reg <= ostatus_next;
            oidx_reg    <= oidx_next;
            ocount_reg  <= ocount_next;
            oentry_reg  <= oentry_next;
            olast_reg   <= olast_next;
        end
    end

    // Result port
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {oentry_reg.seen, oentry_reg.strength, oentry_reg.key,
                       ocount_reg, oidx_reg, ostatus_reg};

    // Checks
    `DTA_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `DTA_ASSERT_NOW(a_write_states, aclk, aresetn, ram_wr_en,
        state_reg == dta_pkg::S_OBS_DONE || state_reg == dta_pkg::S_EXP_MOVE)
    `DTA_ASSERT_NOW(a_move_nonempty, aclk, aresetn, state_reg == dta_pkg::S_EXP_MOVE,
        count_reg != '0 && ptr_reg < count_reg)
    `DTA_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, out_load && olast_next,
        state_reg == dta_pkg::S_IDLE)

endmodule

FILE: bench/device_table_aging_checker.sv
`timescale 1ns / 1ps

module device_table_aging_checker #(
    parameter int DEPTH = dta_pkg::TABLE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wen,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  s_tdata,   // device_address[47:0], signal_strength[55:48],
                                    // now_ms[87:56], max_out[94:88], zero pad[95]
    input  logic [1:0]   s_tuser,   // command[1:0]
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,   // status[2:0], entry_index[8:3], entry_count[15:9],
                                    // entry_address[63:16], entry_strength[71:64],
                                    // entry_last_seen[103:72]
    input  logic         m_tlast,
    output int           error_count,
    output int           pending_count,
    output int           checked_count
);

    // One result as it should leave the block
    typedef struct {
        dta_pkg::status_t status;
        logic [5:0]       index;
        logic [6:0]       count;
        logic [47:0]      address;
        logic [7:0]       strength;
        logic [31:0]      last_seen;
        logic             last;
    } dev_result_t;

    dev_result_t result_queue[$];

    // Shadow copy of the device table and the expiry age
    logic [47:0] tbl_key      [DEPTH];
    logic [7:0]  tbl_strength [DEPTH];
    logic [31:0] tbl_seen     [DEPTH];
    int          tbl_count;
    logic [31:0] age_limit;
    int          mismatches;
    int          checked;

    // Queue one result, taking the entry fields from a slot or leaving them zero
    function automatic void queue_result(input dta_pkg::status_t st, input int slot,
                                         input bit from_table, input bit last);
        dev_result_t r;
        r.status = st;
        r.count  = 7'(tbl_count);
        r.last   = last;
        if (from_table) begin
            r.index     = 6'(slot);
            r.address   = tbl_key[slot];
            r.strength  = tbl_strength[slot];
            r.last_seen = tbl_seen[slot];
        end else begin
            r.index     = '0;
            r.address   = '0;
            r.strength  = '0;
            r.last_seen = '0;
        end
        result_queue.push_back(r);
    endfunction

    // Apply one accepted item to the shadow table and queue its results
    task automatic table_step(input logic [1:0] cmd, input logic [47:0] addr,
                              input logic [7:0] rssi, input logic [31:0] stamp,
                              input logic [6:0] dump_max);
        int          i;
        int          slot;
        int          n;
        logic [31:0] age;
        case (cmd)
            dta_pkg::CMD_OBSERVE: begin
                slot = -1;
                for (i = 0; i < tbl_count; i++) begin
                    if (slot < 0 && tbl_key[i] == addr)
                        slot = i;
                end
                if (slot >= 0) begin
                    tbl_strength[slot] = rssi;
                    tbl_seen[slot]     = stamp;
                    queue_result(dta_pkg::ST_UPDATED, slot, 1'b1, 1'b1);
                end else if (tbl_count < DEPTH) begin
                    slot = tbl_count;
                    tbl_key[slot]      = addr;
                    tbl_strength[slot] = rssi;
                    tbl_seen[slot]     = stamp;
                    tbl_count++;
                    queue_result(dta_pkg::ST_INSERTED, slot, 1'b1, 1'b1);
                end else begin
                    queue_result(dta_pkg::ST_DROPPED, 0, 1'b0, 1'b1);
                end
            end
            dta_pkg::CMD_EXPIRE: begin
                // Refill a removed slot from the tail and look at it again
                i = 0;
                while (i < tbl_count) begin
                    age = stamp - tbl_seen[i];
                    if (age > age_limit) begin
                        tbl_count--;
                        tbl_key[i]      = tbl_key[tbl_count];
                        tbl_strength[i] = tbl_strength[tbl_count];
                        tbl_seen[i]     = tbl_seen[tbl_count];
                    end else begin
                        i++;
                    end
                end
                queue_result(dta_pkg::ST_EXPIRED, 0, 1'b0, 1'b1);
            end
            dta_pkg::CMD_DUMP: begin
                n = tbl_count;
                if (int'(dump_max) < n)
                    n = dump_max;
                if (int'(dta_pkg::MAX_DUMP) < n)
                    n = dta_pkg::MAX_DUMP;
                if (n == 0)
                    queue_result(dta_pkg::ST_DUMP_EMPTY, 0, 1'b0, 1'b1);
                for (i = 0; i < n; i++)
                    queue_result(dta_pkg::ST_DUMP_ENTRY, i, 1'b1, i == n - 1);
            end
            default: begin
                // unused command: no result, table untouched
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic compare_result();
        dev_result_t want;
        if (result_queue.size() == 0) begin
            $error("result with no expectation: tdata %h tlast %b", m_tdata, m_tlast);
            mismatches++;
        end else begin
            want = result_queue.pop_front();
            check_field("status", 64'(want.status), 64'(m_tdata[2:0]));
            check_field("entry_index", 64'(want.index), 64'(m_tdata[8:3]));
            check_field("entry_count", 64'(want.count), 64'(m_tdata[15:9]));
            check_field("entry_address", 64'(want.address), 64'(m_tdata[63:16]));
            check_field("entry_strength", 64'(want.strength), 64'(m_tdata[71:64]));
            check_field("entry_last_seen", 64'(want.last_seen), 64'(m_tdata[103:72]));
            check_field("last", 64'(want.last), 64'(m_tlast));
            checked++;
        end
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            tbl_count  = 0;
            age_limit  = dta_pkg::TIMEOUT_RESET;
            mismatches = 0;
            checked    = 0;
            result_queue.delete();
        end else begin
            if (cfg_wen)
                age_limit = cfg_wdata;
            if (s_tvalid && s_tready)
                table_step(s_tuser, s_tdata[47:0], s_tdata[55:48], s_tdata[87:56],
                           s_tdata[94:88]);
            if (m_tvalid && m_tready)
                compare_result();
        end
        error_count   <= mismatches;
        pending_count <= result_queue.size();
        checked_count <= checked;
    end

endmodule

FILE: bench/device_table_aging_tb.sv
`timescale 1ns / 1ps

module device_table_aging_tb;

    localparam int         DRAIN_CYCLES = 300;
    localparam int         POOL_SIZE    = 12;
    localparam int         PHASE_ITEMS  = 13;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wen;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // device_address[47:0], signal_strength[55:48],
                             // now_ms[87:56], max_out[94:88], zero pad[95]
    logic [1:0]   s_tuser;   // command[1:0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;   // status[2:0], entry_index[8:3], entry_count[15:9],
                             // entry_address[63:16], entry_strength[71:64],
                             // entry_last_seen[103:72]
    logic         m_tlast;

    int          error_count;
    int          pending_count;
    int          checked_count;
    bit          steady = 1'b0;
    logic [31:0] now_stamp;
    logic [31:0] random_limit;
    logic [47:0] addr_pool [POOL_SIZE];
    int          n_observe;
    int          n_expire;
    int          n_dump;
    int          n_unused;

    device_table_aging DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    device_table_aging_checker table_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result side at random, except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 17);
    end

    // Offer one item and hold it until the transfer; valid stays high afterward
    task automatic send_item(input logic [1:0] cmd, input logic [47:0] addr,
                             input logic [7:0] rssi, input logic [31:0] stamp,
                             input logic [6:0] dump_max);
        if (!steady && $urandom_range(0, 99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, dump_max, stamp, rssi, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (cmd)
            dta_pkg::CMD_OBSERVE: n_observe++;
            dta_pkg::CMD_EXPIRE:  n_expire++;
            dta_pkg::CMD_DUMP:    n_dump++;
            default:              n_unused++;
        endcase
    endtask

    // Drop valid, wait for every queued result, then let the block settle
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        drain(DRAIN_CYCLES);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Mostly observes from a small address pool so that hits and expiry chains occur
    task automatic random_item(input logic [31:0] step_max);
        int          pick;
        logic [47:0] addr;
        logic [31:0] stamp;
        logic [6:0]  dump_max;
        pick      = $urandom_range(0, 99);
        now_stamp = now_stamp + $urandom_range(0, step_max);
        stamp     = ($urandom_range(0, 99) < 5) ? $urandom : now_stamp;
        if ($urandom_range(0, 99) < 80)
            addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            addr = {16'($urandom), $urandom};
        dump_max = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 70))
                                                 : 7'($urandom_range(64, 127));
        if (pick < 56)
            send_item(dta_pkg::CMD_OBSERVE, addr, 8'($urandom), stamp, 7'($urandom));
        else if (pick < 72)
            send_item(dta_pkg::CMD_EXPIRE, addr, 8'($urandom), stamp, 7'($urandom));
        else if (pick < 95)
            send_item(dta_pkg::CMD_DUMP, addr, 8'($urandom), stamp, dump_max);
        else
            send_item(CMD_UNUSED, addr, 8'($urandom), stamp, 7'($urandom));
    endtask

    initial begin
        logic [31:0] limit_ms;
        logic [31:0] step_ms;
        aresetn   <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        n_observe = 0;
        n_expire  = 0;
        n_dump    = 0;
        n_unused  = 0;
        now_stamp = 32'h0001_D4E1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        addr_pool[2] = 48'hAAAA_AAAA_AAAA;
        for (int k = 3; k < POOL_SIZE; k++)
            addr_pool[k] = {16'($urandom), $urandom};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, extremes, wrapping ages, exact-timeout boundary
        send_item(dta_pkg::CMD_DUMP,    48'h0, 8'h00, 32'h0, 7'd5);
        send_item(dta_pkg::CMD_EXPIRE,  48'h0, 8'h00, 32'h0, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, 48'h0, 8'h80, 32'hFFFF_FFF0, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, '1, 8'h7F, 32'hFFFF_FFFF, 7'h7F);
        send_item(dta_pkg::CMD_OBSERVE, 48'h1, 8'h00, 32'h0000_0010, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, 48'h0, 8'hFF, 32'h0000_0020, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, 48'h2, 8'h01, 32'h0000_0021, 7'd0);
        send_item(dta_pkg::CMD_DUMP,    48'h0, 8'h00, 32'h0, 7'd0);
        send_item(dta_pkg::CMD_DUMP,    48'h0, 8'h00, 32'h0, 7'd1);
        send_item(dta_pkg::CMD_DUMP,    '1, 8'hFF, '1, 7'd64);
        send_item(dta_pkg::CMD_DUMP,    48'h0, 8'h00, 32'h0, 7'h7F);
        send_item(CMD_UNUSED, {16'($urandom), $urandom}, 8'($urandom), $urandom,
                  7'($urandom));
        send_item(dta_pkg::CMD_EXPIRE,  48'h0, 8'h00, 32'h0000_0100, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, 48'hAAAA_AAAA_AAAA, 8'h55, 32'h0000_0100, 7'd0);
        send_item(dta_pkg::CMD_OBSERVE, 48'h5555_5555_5555, 8'hAA, 32'h0001_D4C0, 7'd0);
        send_item(dta_pkg::CMD_EXPIRE,  48'h0, 8'h00, 32'h0001_D4E1, 7'd0);
        send_item(dta_pkg::CMD_DUMP,    48'h0, 8'h00, 32'h0, 7'd64);

        // Random phases, one expiry age each
        random_limit = $urandom;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0:       begin limit_ms = 32'd0;                 step_ms = 32'd3;       end
                1:       begin limit_ms = 32'hFFFF_FFFF;         step_ms = 32'hFFFF_FFFF; end
                2:       begin limit_ms = 32'd50;                step_ms = 32'd30;      end
                3:       begin limit_ms = dta_pkg::TIMEOUT_RESET; step_ms = 32'd50000;  end
                default: begin limit_ms = random_limit;          step_ms = random_limit >> 2; end
            endcase
            write_timeout(limit_ms);
            steady <= (p == 2);
            // Nothing expires here: fill the table past full, then dump it all
            if (p == 1) begin
                repeat (dta_pkg::TABLE_DEPTH_DEF + 2) begin
                    now_stamp = now_stamp + $urandom_range(0, 100);
                    send_item(dta_pkg::CMD_OBSERVE, {16'($urandom), $urandom},
                              8'($urandom), now_stamp, 7'($urandom));
                end
                send_item(dta_pkg::CMD_DUMP, 48'h0, 8'h00, now_stamp, 7'd64);
                send_item(dta_pkg::CMD_DUMP, 48'h0, 8'h00, now_stamp, 7'h7F);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2)
                    drain(0);
                random_item(step_ms);
            end
        end

        drain(DRAIN_CYCLES);
        $display("covered %0d observe, %0d expire, %0d dump, %0d unused-command items; %0d results",
                 n_observe, n_expire, n_dump, n_unused, checked_count);
        $display("expiry ages: reset value, 0, all ones, 50, 120000 and %0d; table filled past full",
                 random_limit);
        if (pending_count != 0)
            $error("%0d expected results never arrived", pending_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("PASS device_table_aging");
        end else begin
            $display("FAIL device_table_aging");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL device_table_aging");
        $finish;
    end

endmodule

FILE: device_table_aging.f
+incdir+rtl
rtl/dta_pkg.sv
rtl/dta_ram.sv
rtl/device_table_aging.sv
bench/device_table_aging_checker.sv
bench/device_table_aging_tb.sv
